// File: rtl/lzwd_pkg.sv
// Shared constants and controller/datapath interface types for the LZW code decoder.
package lzwd_pkg;

  localparam int CODE_W    = 9;
  localparam int BYTE_W    = 8;
  localparam int CHUNK_W   = 64;
  localparam int COUNT_W   = 4;
  localparam int BYTE_MAX  = 255;
  localparam int ALPHABET  = BYTE_MAX + 1;
  localparam int FIRST_FREE = ALPHABET + 1;
  localparam int MAX_RESULTS = 64;

  localparam int TABLE_CODES_DEF     = 512;
  localparam int BYTES_PER_CHUNK_DEF = 8;

  localparam logic [CODE_W-1:0] CLEAR_CODE = '0;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic start_walk;
    logic walk_step;
    logic kwk;
    logic emit_init;
    logic emit_step;
    logic load_chunk;
    logic load_error;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_clear;
    logic is_known;
    logic is_kwk;
    logic walk_last;
    logic chunk_done;
    logic chunk_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/lzwd_ctrl.sv
// Sequencing state machine of the LZW code decoder.
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT,
    ST_ERROR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (stat.is_clear) begin
            cmd.clear = 1'b1;
          end else if (stat.is_known) begin
            cmd.start_walk = 1'b1;
            state_next     = ST_WALK;
          end else if (stat.is_kwk) begin
            cmd.kwk       = 1'b1;
            cmd.emit_init = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            state_next = ST_ERROR;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (stat.chunk_done && stat.out_free) begin
          cmd.load_chunk = 1'b1;
          if (stat.chunk_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERROR: begin
        if (stat.out_free) begin
          cmd.load_error = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

// File: rtl/lzwd_datapath.sv
// Dictionary, string store, chunk packer and output register of the LZW code decoder.
module lzwd_datapath import lzwd_pkg::*; #(
  parameter int TABLE_CODES     = TABLE_CODES_DEF,
  parameter int BYTES_PER_CHUNK = BYTES_PER_CHUNK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CODE_W-1:0]  code,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [CHUNK_W-1:0] chunk,
  output logic [COUNT_W-1:0] byte_count,
  output logic               last_chunk,
  output logic               status,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int IDX_W  = $clog2(TABLE_CODES);
  localparam int NF_W   = $clog2(TABLE_CODES + 1);
  localparam int LEN_W  = $clog2(TABLE_CODES + 1);
  localparam int LANE_W = $clog2(BYTES_PER_CHUNK + 1);
  localparam int NCH_W  = $clog2(MAX_RESULTS);
  localparam int ENT_W  = CODE_W + BYTE_W;

  // dictionary state
  logic [NF_W-1:0]   next_free;
  logic [CODE_W-1:0] prior_code;
  logic [CODE_W-1:0] walk_code;
  logic [LEN_W-1:0]  str_len;
  logic [LEN_W-1:0]  walk_len;
  logic [BYTE_W-1:0] first_byte;

  // entry memory: {parent, byte}; only entries above the single bytes are stored
  logic [ENT_W-1:0]  ent_mem [TABLE_CODES];
  logic [IDX_W-1:0]  ent_rd_addr;
  logic [IDX_W-1:0]  ent_addr_q;
  logic [ENT_W-1:0]  ent_q;
  logic [IDX_W-1:0]  ent_dec;
  logic              ent_single;
  logic [CODE_W-1:0] ent_parent;
  logic [BYTE_W-1:0] ent_byte;
  logic              add_en;
  logic [BYTE_W-1:0] add_byte;

  // string store, held in walk order (last byte at index 0)
  logic [BYTE_W-1:0] str_mem [TABLE_CODES];
  logic [IDX_W-1:0]  str_rd_addr;
  logic [LEN_W-1:0]  str_rd_full;
  logic [BYTE_W-1:0] str_q;

  // chunk packer
  logic [LEN_W-1:0]   pos;
  logic [LANE_W-1:0]  lane;
  logic [LANE_W-1:0]  land_lane;
  logic               land_v;
  logic               land_first;
  logic [BYTE_W-1:0]  land_byte;
  logic [CHUNK_W-1:0] acc;
  logic [CHUNK_W-1:0] merged;
  logic [NCH_W-1:0]   nchunk;
  logic               can_issue;
  logic               out_free;
  logic [NF_W-1:0]    code_ext;

  assign code_ext = NF_W'(code);

  // single-byte codes are fixed: parent none, byte is code minus one
  assign ent_single = (ent_addr_q <= IDX_W'(ALPHABET));
  assign ent_dec    = ent_addr_q - IDX_W'(1);
  assign ent_byte   = ent_single ? ent_dec[BYTE_W-1:0] : ent_q[BYTE_W-1:0];
  assign ent_parent = ent_single ? '0 : ent_q[ENT_W-1:BYTE_W];

  assign ent_rd_addr = cmd.start_walk ? IDX_W'(code) : IDX_W'(ent_parent);

  assign add_en   = ((cmd.walk_step && stat.walk_last) || cmd.kwk) &&
                    (prior_code != '0) && (next_free < NF_W'(TABLE_CODES));
  assign add_byte = cmd.kwk ? first_byte : ent_byte;

  assign can_issue   = (lane < LANE_W'(BYTES_PER_CHUNK)) && (pos < str_len);
  assign str_rd_full = walk_len - LEN_W'(1) - pos;
  assign str_rd_addr = str_rd_full[IDX_W-1:0];
  assign land_byte   = land_first ? first_byte : str_q;
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    merged = acc;
    for (int i = 0; i < BYTES_PER_CHUNK; i++) begin
      if (land_v && (land_lane == LANE_W'(i))) begin
        merged[i*BYTE_W +: BYTE_W] = land_byte;
      end
    end
  end

  always_comb begin
    stat.is_clear   = (code == CLEAR_CODE);
    stat.is_known   = (code != CLEAR_CODE) && (code_ext < next_free);
    stat.is_kwk     = (code_ext == next_free) && (next_free < NF_W'(TABLE_CODES)) &&
                      (prior_code != '0) && (str_len != '0) &&
                      (str_len < LEN_W'(TABLE_CODES));
    stat.walk_last  = (ent_parent == '0);
    stat.chunk_done = !can_issue;
    stat.chunk_last = (pos == str_len) || (nchunk == NCH_W'(MAX_RESULTS - 1));
    stat.out_free   = out_free;
  end

  // memories
  always_ff @(posedge clk) begin
    if (add_en) begin
      ent_mem[next_free[IDX_W-1:0]] <= {prior_code, add_byte};
    end
    ent_addr_q <= ent_rd_addr;
    ent_q      <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      str_mem[walk_len[IDX_W-1:0]] <= ent_byte;
    end
    str_q <= str_mem[str_rd_addr];
  end

  // dictionary and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= NF_W'(FIRST_FREE);
      prior_code <= '0;
      str_len    <= '0;
      walk_len   <= '0;
    end else begin
      if (cmd.clear) begin
        next_free  <= NF_W'(FIRST_FREE);
        prior_code <= '0;
        str_len    <= '0;
        walk_len   <= '0;
      end else begin
        if (add_en) begin
          next_free <= next_free + NF_W'(1);
        end
        if (cmd.start_walk) begin
          walk_len <= '0;
        end else if (cmd.walk_step) begin
          walk_len <= walk_len + LEN_W'(1);
          if (stat.walk_last) begin
            str_len    <= walk_len + LEN_W'(1);
            prior_code <= walk_code;
          end
        end
        if (cmd.kwk) begin
          str_len    <= str_len + LEN_W'(1);
          prior_code <= code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      walk_code <= code;
    end
    if (cmd.walk_step && stat.walk_last) begin
      first_byte <= ent_byte;
    end
  end

  // chunk packer
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      pos    <= '0;
      lane   <= '0;
      acc    <= '0;
      nchunk <= '0;
    end else if (cmd.load_chunk) begin
      lane   <= '0;
      acc    <= '0;
      nchunk <= nchunk + NCH_W'(1);
    end else if (cmd.emit_step) begin
      acc <= merged;
      if (can_issue) begin
        pos        <= pos + LEN_W'(1);
        lane       <= lane + LANE_W'(1);
        land_lane  <= lane;
        land_first <= !(pos < walk_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      land_v <= 1'b0;
    end else begin
      land_v <= cmd.emit_step && !cmd.load_chunk && can_issue;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_chunk || cmd.load_error) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_chunk) begin
      chunk      <= merged;
      byte_count <= COUNT_W'(lane);
      last_chunk <= stat.chunk_last;
      status     <= STATUS_OK;
    end else if (cmd.load_error) begin
      chunk      <= '0;
      byte_count <= '0;
      last_chunk <= 1'b1;
      status     <= STATUS_BAD;
    end
  end

  a_next_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free >= NF_W'(FIRST_FREE)) && (next_free <= NF_W'(TABLE_CODES)))
    else $error("next free code out of range");

  a_prev_has_string: assert property (@(posedge clk) disable iff (rst)
    (prior_code != '0) |-> (str_len != '0))
    else $error("previous code held with empty string");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_chunk || cmd.load_error) |-> out_free)
    else $error("output register overwritten while held");

  a_chunk_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_chunk |=> (byte_count != '0))
    else $error("empty chunk delivered");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> (pos <= str_len))
    else $error("packer read position beyond string");

endmodule

// File: rtl/lzw_code_decoder.sv
// Top level of the LZW code decoder: controller plus datapath.
//
// Takes one 9-bit LZW code per request on the input channel and returns the
// decoded string as chunks of up to BYTES_PER_CHUNK bytes (earliest byte in
// bits 7:0, unused upper lanes zero), the final chunk of a code marked by
// last_chunk. Code 0 clears the dictionary and yields no chunk. A code above
// the next free code, or a KwKwK code with no previous code, yields one chunk
// with byte_count 0, last_chunk 1 and status 1, and changes nothing. Codes are
// taken one at a time. For a known code the parent chain is walked one entry
// per cycle through the dictionary memory's single read port, then the string
// store is read back one byte per cycle until a chunk is full; the full chunk
// is loaded into the output register once that register is free, and reading
// goes on into the next chunk. A KwKwK code skips the walk; it reads back the
// previous string and then its first byte once more. A
// finished chunk waits in the output register, and the next code is accepted
// while the final chunk of the previous one is still held there. No clearing
// pass is needed after reset or a clear code: the next free code marks which
// dictionary entries are live, and the single-byte entries are fixed logic.
// Strings longer than 64 chunks are cut at 64, the 64th marked last.
module lzw_code_decoder import lzwd_pkg::*; #(
  parameter int TABLE_CODES     = TABLE_CODES_DEF,
  parameter int BYTES_PER_CHUNK = BYTES_PER_CHUNK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CODE_W-1:0]  code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHUNK_W-1:0] chunk,
  output logic [COUNT_W-1:0] byte_count,
  output logic               last_chunk,
  output logic               status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzwd_datapath #(
    .TABLE_CODES     (TABLE_CODES),
    .BYTES_PER_CHUNK (BYTES_PER_CHUNK)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .code       (code),
    .cmd        (cmd),
    .stat       (stat),
    .chunk      (chunk),
    .byte_count (byte_count),
    .last_chunk (last_chunk),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

// File: test/tb_lzw_code_decoder.sv
// Self-checking testbench for the LZW code decoder: directed and random code streams against a local decoder.
`timescale 1ns / 100ps

module tb_lzw_code_decoder;
  import lzwd_pkg::*;

  localparam int TABLE_CODES     = TABLE_CODES_DEF;
  localparam int BYTES_PER_CHUNK = BYTES_PER_CHUNK_DEF;
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int END_CYCLES      = 60;   // settle time after the last chunk

  // one decoded chunk as the block should present it
  typedef struct packed {
    logic [CHUNK_W-1:0] bytes;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               stat;
  } chunk_res_t;

  // one pending code request with its lead-in gap
  typedef struct {
    logic [CODE_W-1:0] value;
    int                gap;
    bit                drain;  // hold until every chunk so far has come back
  } code_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CODE_W-1:0]  code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHUNK_W-1:0] chunk;
  logic [COUNT_W-1:0] byte_count;
  logic               last_chunk;
  logic               status;

  lzw_code_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code       (code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .chunk      (chunk),
    .byte_count (byte_count),
    .last_chunk (last_chunk),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local decoder: dictionary, previous code and the current string
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] dict_parent [TABLE_CODES];
  logic [BYTE_W-1:0] dict_byte   [TABLE_CODES];
  logic [9:0]        dict_next;
  logic [CODE_W-1:0] last_code;
  logic [BYTE_W-1:0] str_bytes   [TABLE_CODES];
  logic [9:0]        str_len;

  chunk_res_t expected_chunks [$];

  function automatic void reset_dictionary();
    for (int i = 0; i < TABLE_CODES; i++) begin
      dict_parent[i] = '0;
      dict_byte[i]   = '0;
    end
    for (int b = 0; b <= BYTE_MAX; b++) dict_byte[1 + b] = b[BYTE_W-1:0];
    dict_next = 10'(FIRST_FREE);
    last_code = '0;
    str_len   = '0;
  endfunction

  // no new entries once the table is full
  function automatic void add_entry(logic [CODE_W-1:0] parent, logic [BYTE_W-1:0] b);
    if (dict_next < TABLE_CODES) begin
      dict_parent[dict_next[CODE_W-1:0]] = parent;
      dict_byte[dict_next[CODE_W-1:0]]   = b;
      dict_next++;
    end
  endfunction

  // Decode one code and queue the chunks it should produce.
  function automatic void decode_lzw_code(logic [CODE_W-1:0] c);
    int                 n_len;
    int                 pos;
    int                 k;
    int                 n_out;
    logic [CODE_W-1:0]  cur;
    logic [BYTE_W-1:0]  first;
    logic [CHUNK_W-1:0] ch;
    chunk_res_t         res;

    if (c == CLEAR_CODE) begin
      reset_dictionary();
      return;
    end

    if (c < dict_next) begin
      // known code: measure the chain, then fill the string back to front
      n_len = 0;
      cur   = c;
      while (cur != 0 && n_len < TABLE_CODES) begin
        n_len++;
        cur = dict_parent[cur];
      end
      pos = n_len;
      cur = c;
      while (pos > 0) begin
        pos--;
        str_bytes[pos] = dict_byte[cur];
        cur = dict_parent[cur];
      end
      str_len = 10'(n_len);
      if (last_code != 0) add_entry(last_code, str_bytes[0]);
      last_code = c;
    end else if (c == dict_next && dict_next < TABLE_CODES && last_code != 0 &&
                 str_len > 0 && str_len < TABLE_CODES) begin
      // KwKwK: previous string plus its own first byte
      first = str_bytes[0];
      add_entry(last_code, first);
      str_bytes[str_len[CODE_W-1:0]] = first;
      str_len++;
      last_code = c;
    end else begin
      res.bytes = '0;
      res.count = '0;
      res.last  = 1'b1;
      res.stat  = STATUS_BAD;
      expected_chunks.push_back(res);
      return;
    end

    pos   = 0;
    n_out = 0;
    do begin
      ch = '0;
      k  = 0;
      while (k < BYTES_PER_CHUNK && pos < str_len) begin
        ch[8*k +: 8] = str_bytes[pos];
        k++;
        pos++;
      end
      res.bytes = ch;
      res.count = k[COUNT_W-1:0];
      res.last  = (pos >= str_len || n_out == MAX_RESULTS - 1);
      res.stat  = STATUS_OK;
      expected_chunks.push_back(res);
      n_out++;
    end while (pos < str_len && n_out < MAX_RESULTS);
  endfunction

  // ---------------------------------------------------------------------------
  // Request queue and a light tracker so that the stream stays mostly well formed
  // ---------------------------------------------------------------------------
  code_req_t code_reqs [$];
  int        n_queued = 0;
  int        gen_next = FIRST_FREE;
  int        gen_prev = 0;
  bit        gen_has_str = 0;

  task automatic queue_code(input logic [CODE_W-1:0] c, input bit drain);
    code_req_t req;
    req.value = c;
    req.drain = drain;
    // every third block of 40 requests goes out back to back
    req.gap   = ((n_queued / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
    code_reqs.push_back(req);
    n_queued++;
    if (c == CLEAR_CODE) begin
      gen_next    = FIRST_FREE;
      gen_prev    = 0;
      gen_has_str = 0;
    end else if (c < gen_next) begin
      if (gen_prev != 0 && gen_next < TABLE_CODES) gen_next++;
      gen_prev    = c;
      gen_has_str = 1;
    end else if (c == gen_next && gen_next < TABLE_CODES && gen_prev != 0 && gen_has_str) begin
      gen_next++;
      gen_prev = c;
    end
  endtask

  // random code, weighted towards codes that decode and towards recent entries
  function automatic logic [CODE_W-1:0] pick_code(bit allow_clear);
    int r;
    int lo;
    r = $urandom_range(0, 99);
    if (allow_clear && r < 4) return CLEAR_CODE;
    if (r < 10) return CODE_W'($urandom_range(0, (1 << CODE_W) - 1));
    if (r < 14 && gen_next < TABLE_CODES - 1)
      return CODE_W'($urandom_range(gen_next + 1, TABLE_CODES - 1));
    if (r < 34 && gen_next < TABLE_CODES) return gen_next[CODE_W-1:0];
    if (r < 70 && gen_next > FIRST_FREE) begin
      lo = (gen_next - 8 > FIRST_FREE) ? gen_next - 8 : FIRST_FREE;
      return CODE_W'($urandom_range(lo, gen_next - 1));
    end
    return CODE_W'($urandom_range(1, ALPHABET));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents requests on the falling edge
  // ---------------------------------------------------------------------------
  bit        in_took  = 0;  // request accepted at the last rising edge
  bit        out_took = 0;  // chunk accepted at the last rising edge
  bit        have_next = 0;
  int        gap_left  = 0;
  code_req_t next_req;
  int        n_accepted = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      code     <= '0;
    end else if (!in_valid || in_took) begin
      if (!have_next && code_reqs.size() != 0) begin
        next_req  = code_reqs.pop_front();
        gap_left  = next_req.gap;
        have_next = 1;
      end
      if (!have_next) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (next_req.drain && expected_chunks.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid  <= 1'b1;
        code      <= next_req.value;
        have_next = 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per chunk, quiet stretches, one long hold-off
  // ---------------------------------------------------------------------------
  bit hold_off = 0;
  int rx_wait  = 0;
  int n_chunks = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) rx_wait = ((n_chunks / 64) % 3 == 1) ? 0 : $urandom_range(0, 6);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hold the output off for a long stretch once long strings are flowing,
  // so the output register fills and the input backs up
  initial begin
    wait (n_accepted >= 60);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: requests feed the decoder, chunks are checked in order
  // ---------------------------------------------------------------------------
  int         n_errors = 0;
  chunk_res_t want;

  always @(posedge clk) begin
    in_took  = 0;
    out_took = 0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_took = 1;
        n_accepted++;
        decode_lzw_code(code);
      end
      if (out_valid && out_ready) begin
        out_took = 1;
        n_chunks++;
        if (expected_chunks.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected chunk %h count %0d last %b status %b",
                     chunk, byte_count, last_chunk, status);
        end else begin
          want = expected_chunks.pop_front();
          if (chunk !== want.bytes || byte_count !== want.count ||
              last_chunk !== want.last || status !== want.stat) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: chunk %0d got %h/%0d/%b/%b want %h/%0d/%b/%b", n_chunks,
                       chunk, byte_count, last_chunk, status,
                       want.bytes, want.count, want.last, want.stat);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n_full;
    int n_rand;

    reset_dictionary();

    // directed: errors straight after reset, single bytes at both ends,
    // KwKwK chains past one chunk, clear, then KwKwK with nothing before it
    queue_code(CODE_W'(FIRST_FREE), 0);       // KwKwK with no previous code
    queue_code(CODE_W'(TABLE_CODES - 1), 0);  // above the next free code
    queue_code(CLEAR_CODE, 0);
    queue_code(CODE_W'(1), 0);                // byte 00
    queue_code(CODE_W'(ALPHABET), 0);         // byte ff
    queue_code(CODE_W'(FIRST_FREE + 1), 0);   // KwKwK
    queue_code(CODE_W'(FIRST_FREE), 0);       // known multi-byte entry
    queue_code(CODE_W'(FIRST_FREE + 4), 0);   // one above next free
    for (int i = 0; i < 10; i++) queue_code(gen_next[CODE_W-1:0], 0);  // string grows past 8
    queue_code(CODE_W'(ALPHABET / 2), 1);     // sender waits for all chunks first
    queue_code(CLEAR_CODE, 0);
    queue_code(CODE_W'(FIRST_FREE), 0);       // KwKwK with no previous code again
    queue_code(9'h155, 0);
    queue_code(9'h0aa, 0);
    queue_code(9'h1ff, 0);

    // mostly well-formed stream without clears until the table is full, and beyond
    n_full = 0;
    n_rand = 0;
    while ((gen_next < TABLE_CODES || n_full < 10) && n_rand < 320) begin
      queue_code(pick_code(0), (n_rand % 90 == 89));
      if (gen_next >= TABLE_CODES) n_full++;
      n_rand++;
    end
    // shorter runs broken up by clears
    for (int i = 0; i < 25; i++) queue_code(pick_code(1), (i == 15));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_queued) @(negedge clk);
    while (expected_chunks.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    if (n_errors == 0 && expected_chunks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: lzw_code_decoder.f
rtl/lzwd_pkg.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lzw_code_decoder.sv
test/tb_lzw_code_decoder.sv
